>>> src/rtch_pkg.sv
// ---------------------------------------------------------------------------
// rtch_pkg: shared types and constants of the ray/triangle closest-hit engine
// Controller states, datapath command and status groups, operand codes and
// the multiply-accumulate program that the controller steps through.
// ---------------------------------------------------------------------------
`default_nettype none

package rtch_pkg;

  localparam int DEF_MAX_TRIANGLES = 256;
  localparam int DEF_FRAC_BITS     = 16;
  localparam int WORDS_PER_TRI     = 9;

  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  // Request codes.
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_TRACE = 1'b1;

  // Register index of triangle_count, as decoded from paddr[2].
  localparam logic CFG_TRI_COUNT = 1'b0;

  // Divider target select.
  localparam logic [1:0] DIV_T = 2'd0;
  localparam logic [1:0] DIV_U = 2'd1;
  localparam logic [1:0] DIV_V = 2'd2;

  // Sequencer counter end values (include the multiplier drain).
  localparam logic [4:0] LOAD_LAST  = 5'd8;
  localparam logic [4:0] FETCH_LAST = 5'd9;
  localparam logic [4:0] FETCH_RDS  = 5'd9;
  localparam logic [4:0] MUL_LAST   = 5'd31;
  localparam logic [4:0] POINT_LAST = 5'd4;

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_TR_START, S_FETCH, S_MUL, S_CHECK,
    S_DIV_START, S_DIV_WAIT, S_TEST, S_POINT, S_NEXT, S_DONE
  } state_t;

  typedef enum logic [5:0] {
    OP_ZERO,
    OP_ORG0, OP_ORG1, OP_ORG2,
    OP_DIR0, OP_DIR1, OP_DIR2,
    OP_NDIR0, OP_NDIR1, OP_NDIR2,
    OP_E0_0, OP_E0_1, OP_E0_2,
    OP_E1_0, OP_E1_1, OP_E1_2,
    OP_SP0, OP_SP1, OP_SP2,
    OP_C01_0, OP_C01_1, OP_C01_2,
    OP_CS1_0, OP_CS1_1, OP_CS1_2,
    OP_C0S_0, OP_C0S_1, OP_C0S_2,
    OP_DET, OP_NT, OP_NU, OP_NV, OP_T,
    OP_BX, OP_BY, OP_BZ
  } opnd_t;

  // One multiply-accumulate step: acc = (first ? sc : acc) +/- sat(sa*sb).
  typedef struct packed {
    logic  valid;
    opnd_t sa;
    opnd_t sb;
    opnd_t sc;
    logic  first;
    logic  sub;
    logic  last;
    opnd_t dst;
  } mop_t;

  typedef struct packed {
    logic       capture;
    logic       wr;
    logic       rd;
    logic [3:0] k;
    mop_t       mop;
    logic       tr_init;
    logic       div_start;
    logic [1:0] div_sel;
    logic       test;
    logic       next;
    logic       finish;
  } cmd_t;

  typedef struct packed {
    logic n_zero;
    logic tri_last;
    logic det_zero;
    logic div_done;
    logic accept;
    logic out_free;
  } sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    if (x > 64'(Q_MAX)) return Q_MAX;
    if (x < 64'(Q_MIN)) return Q_MIN;
    return x[31:0];
  endfunction

  function automatic mop_t mk(input opnd_t a, input opnd_t b, input opnd_t c,
                              input logic first, input logic sub,
                              input logic last, input opnd_t dst);
    mop_t m;
    m.valid = 1'b1;
    m.sa    = a;
    m.sb    = b;
    m.sc    = c;
    m.first = first;
    m.sub   = sub;
    m.last  = last;
    m.dst   = dst;
    return m;
  endfunction

  // Cross products c01 = e0 x e1, cs1 = sp x e1, c0s = e0 x sp, then the
  // four dot products det, t, u and v numerators.
  function automatic mop_t mul_prog(input logic [4:0] s);
    case (s)
      5'd0:  return mk(OP_E0_1, OP_E1_2, OP_ZERO, 1'b1, 1'b0, 1'b0, OP_ZERO);
      5'd1:  return mk(OP_E0_2, OP_E1_1, OP_ZERO, 1'b0, 1'b1, 1'b1, OP_C01_0);
      5'd2:  return mk(OP_E0_2, OP_E1_0, OP_ZERO, 1'b1, 1'b0, 1'b0, OP_ZERO);
      5'd3:  return mk(OP_E0_0, OP_E1_2, OP_ZERO, 1'b0, 1'b1, 1'b1, OP_C01_1);
      5'd4:  return mk(OP_E0_0, OP_E1_1, OP_ZERO, 1'b1, 1'b0, 1'b0, OP_ZERO);
      5'd5:  return mk(OP_E0_1, OP_E1_0, OP_ZERO, 1'b0, 1'b1, 1'b1, OP_C01_2);
      5'd6:  return mk(OP_SP1, OP_E1_2, OP_ZERO, 1'b1, 1'b0, 1'b0, OP_ZERO);
      5'd7:  return mk(OP_SP2, OP_E1_1, OP_ZERO, 1'b0, 1'b1, 1'b1, OP_CS1_0);
      5'd8:  return mk(OP_SP2, OP_E1_0, OP_ZERO, 1'b1, 1'b0, 1'b0, OP_ZERO);
      5'd9:  return mk(OP_SP0, OP_E1_2, OP_ZERO, 1'b0, 1'b1, 1'b1, OP_CS1_1);
      5'd10: return mk(OP_SP0, OP_E1_1, OP_ZERO, 1'b1, 1'b0, 1'b0, OP_ZERO);
      5'd11: return mk(OP_SP1, OP_E1_0, OP_ZERO, 1'b0, 1'b1, 1'b1, OP_CS1_2);
      5'd12: return mk(OP_E0_1, OP_SP2, OP_ZERO, 1'b1, 1'b0, 1'b0, OP_ZERO);
      5'd13: return mk(OP_E0_2, OP_SP1, OP_ZERO, 1'b0, 1'b1, 1'b1, OP_C0S_0);
      5'd14: return mk(OP_E0_2, OP_SP0, OP_ZERO, 1'b1, 1'b0, 1'b0, OP_ZERO);
      5'd15: return mk(OP_E0_0, OP_SP2, OP_ZERO, 1'b0, 1'b1, 1'b1, OP_C0S_1);
      5'd16: return mk(OP_E0_0, OP_SP1, OP_ZERO, 1'b1, 1'b0, 1'b0, OP_ZERO);
      5'd17: return mk(OP_E0_1, OP_SP0, OP_ZERO, 1'b0, 1'b1, 1'b1, OP_C0S_2);
      5'd18: return mk(OP_NDIR0, OP_C01_0, OP_ZERO, 1'b1, 1'b0, 1'b0, OP_ZERO);
      5'd19: return mk(OP_NDIR1, OP_C01_1, OP_ZERO, 1'b0, 1'b0, 1'b0, OP_ZERO);
      5'd20: return mk(OP_NDIR2, OP_C01_2, OP_ZERO, 1'b0, 1'b0, 1'b1, OP_DET);
      5'd21: return mk(OP_SP0, OP_C01_0, OP_ZERO, 1'b1, 1'b0, 1'b0, OP_ZERO);
      5'd22: return mk(OP_SP1, OP_C01_1, OP_ZERO, 1'b0, 1'b0, 1'b0, OP_ZERO);
      5'd23: return mk(OP_SP2, OP_C01_2, OP_ZERO, 1'b0, 1'b0, 1'b1, OP_NT);
      5'd24: return mk(OP_NDIR0, OP_CS1_0, OP_ZERO, 1'b1, 1'b0, 1'b0, OP_ZERO);
      5'd25: return mk(OP_NDIR1, OP_CS1_1, OP_ZERO, 1'b0, 1'b0, 1'b0, OP_ZERO);
      5'd26: return mk(OP_NDIR2, OP_CS1_2, OP_ZERO, 1'b0, 1'b0, 1'b1, OP_NU);
      5'd27: return mk(OP_NDIR0, OP_C0S_0, OP_ZERO, 1'b1, 1'b0, 1'b0, OP_ZERO);
      5'd28: return mk(OP_NDIR1, OP_C0S_1, OP_ZERO, 1'b0, 1'b0, 1'b0, OP_ZERO);
      5'd29: return mk(OP_NDIR2, OP_C0S_2, OP_ZERO, 1'b0, 1'b0, 1'b1, OP_NV);
      default: return '0;
    endcase
  endfunction

  // Hit point = origin + t * direction.
  function automatic mop_t point_prog(input logic [4:0] s);
    case (s)
      5'd0:    return mk(OP_T, OP_DIR0, OP_ORG0, 1'b1, 1'b0, 1'b1, OP_BX);
      5'd1:    return mk(OP_T, OP_DIR1, OP_ORG1, 1'b1, 1'b0, 1'b1, OP_BY);
      5'd2:    return mk(OP_T, OP_DIR2, OP_ORG2, 1'b1, 1'b0, 1'b1, OP_BZ);
      default: return '0;
    endcase
  endfunction

endpackage

`default_nettype wire

>>> src/rtch_ctrl.sv
// ---------------------------------------------------------------------------
// rtch_ctrl: sequencer of the closest-hit engine
// Walks load and trace requests through fetch, multiply, divide, test and
// hit-point phases and drives the datapath with one command group per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module rtch_ctrl import rtch_pkg::*; (
  input  wire  clk,
  input  wire  rst_n,
  input  wire  in_valid,
  input  wire  in_req_type,
  input  sts_t sts,
  output logic in_ready,
  output cmd_t cmd
);

  state_t     state_r, state_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic [1:0] dsel_r, dsel_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      dsel_r  <= DIV_T;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      dsel_r  <= dsel_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    dsel_nxt  = dsel_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cnt_nxt   = '0;
          state_nxt = (in_req_type == REQ_LOAD) ? S_LOAD : S_TR_START;
        end
      end
      S_LOAD: begin
        if (cnt_r == LOAD_LAST) state_nxt = S_IDLE;
        else cnt_nxt = cnt_r + 5'd1;
      end
      S_TR_START: begin
        cnt_nxt   = '0;
        state_nxt = sts.n_zero ? S_DONE : S_FETCH;
      end
      S_FETCH: begin
        if (cnt_r == FETCH_LAST) begin
          cnt_nxt   = '0;
          state_nxt = S_MUL;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      S_MUL: begin
        if (cnt_r == MUL_LAST) state_nxt = S_CHECK;
        else cnt_nxt = cnt_r + 5'd1;
      end
      S_CHECK: begin
        dsel_nxt  = DIV_T;
        state_nxt = sts.det_zero ? S_NEXT : S_DIV_START;
      end
      S_DIV_START: state_nxt = S_DIV_WAIT;
      S_DIV_WAIT: begin
        if (sts.div_done) begin
          if (dsel_r == DIV_V) begin
            state_nxt = S_TEST;
          end else begin
            dsel_nxt  = dsel_r + 2'd1;
            state_nxt = S_DIV_START;
          end
        end
      end
      S_TEST: begin
        cnt_nxt   = '0;
        state_nxt = sts.accept ? S_POINT : S_NEXT;
      end
      S_POINT: begin
        if (cnt_r == POINT_LAST) state_nxt = S_NEXT;
        else cnt_nxt = cnt_r + 5'd1;
      end
      S_NEXT: begin
        cnt_nxt   = '0;
        state_nxt = sts.tri_last ? S_DONE : S_FETCH;
      end
      S_DONE: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_LOAD: begin
        cmd.wr = 1'b1;
        cmd.k  = cnt_r[3:0];
      end
      S_TR_START: cmd.tr_init = 1'b1;
      S_FETCH: begin
        cmd.rd = (cnt_r < FETCH_RDS);
        cmd.k  = cnt_r[3:0];
      end
      S_MUL:   cmd.mop = mul_prog(cnt_r);
      S_DIV_START: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = dsel_r;
      end
      S_TEST:  cmd.test = 1'b1;
      S_POINT: cmd.mop = point_prog(cnt_r);
      S_NEXT:  cmd.next = 1'b1;
      S_DONE:  cmd.finish = sts.out_free;
      default: cmd = '0;
    endcase
  end

  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |-> state_r == S_DIV_WAIT)
    else $error("divider finished outside its wait state");

  a_mop_phase: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mop.valid |-> (state_r == S_MUL || state_r == S_POINT))
    else $error("multiply step issued outside a multiply phase");

  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> sts.out_free)
    else $error("result written over an untaken result");

endmodule

`default_nettype wire

>>> src/rtch_dp.sv
// ---------------------------------------------------------------------------
// rtch_dp: datapath of the closest-hit engine
// Triangle memory, one shared multiply-accumulate unit, a radix-2 divider,
// the accept test and the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module rtch_dp import rtch_pkg::*; #(
  parameter int MAX_TRIANGLES = DEF_MAX_TRIANGLES,
  parameter int FRAC_BITS     = DEF_FRAC_BITS
) (
  input  wire                clk,
  input  wire                rst_n,
  input  cmd_t               cmd,
  input  wire  [8:0]         tri_count,
  input  wire  [7:0]         in_slot,
  input  wire  signed [31:0] in_a0,
  input  wire  signed [31:0] in_a1,
  input  wire  signed [31:0] in_a2,
  input  wire  signed [31:0] in_a3,
  input  wire  signed [31:0] in_a4,
  input  wire  signed [31:0] in_a5,
  input  wire  signed [31:0] in_a6,
  input  wire  signed [31:0] in_a7,
  input  wire  signed [31:0] in_a8,
  input  wire                in_shadow_mode,
  input  wire                out_ready,
  output logic               out_valid,
  output logic               out_hit,
  output logic signed [31:0] out_distance,
  output logic signed [31:0] out_point_x,
  output logic signed [31:0] out_point_y,
  output logic signed [31:0] out_point_z,
  output logic [7:0]         out_tri_index,
  output sts_t               sts
);

  localparam int DEPTH = MAX_TRIANGLES * WORDS_PER_TRI;
  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = $clog2(MAX_TRIANGLES + 1);
  localparam int NW    = 32 + FRAC_BITS;
  localparam int CW    = $clog2(NW + 1);
  localparam logic signed [31:0] ONE_Q = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [31:0] EPS_Q = 32'(((1 << FRAC_BITS) + 500) / 1000);

  logic signed [31:0] mem [DEPTH];

  logic signed [31:0] a_r [WORDS_PER_TRI];
  logic               shadow_r;
  logic [AW-1:0]      slot_base_r;
  logic               slot_ok_r;

  logic [AW-1:0]      tri_base_r;
  logic [IW-1:0]      i_r;
  logic [IW-1:0]      n_eff;
  logic signed [31:0] rd_data_r;
  logic               rd_v_r;
  logic [3:0]         rd_k_r;

  logic signed [31:0] ndir_r [3];
  logic signed [31:0] v0_r [3];
  logic signed [31:0] e0_r [3];
  logic signed [31:0] e1_r [3];
  logic signed [31:0] sp_r [3];
  logic signed [31:0] c01_r [3];
  logic signed [31:0] cs1_r [3];
  logic signed [31:0] c0s_r [3];
  logic signed [31:0] det_r, nt_r, nu_r, nv_r, t_r, u_r, v_r;
  logic signed [31:0] best_r, bx_r, by_r, bz_r;
  logic [IW-1:0]      idx_r;
  logic               found_r;

  // Multiply-accumulate pipeline.
  logic signed [31:0] opa, opb, opc;
  logic signed [63:0] prod_r;
  logic signed [31:0] opc_r;
  mop_t               mop_r;
  logic               mul_v_r;
  logic signed [33:0] acc_r;
  logic signed [31:0] p;
  logic signed [33:0] base, acc_new;
  logic signed [31:0] acc_sat;

  // Divider.
  logic [NW-1:0]      dvd_r;
  logic [31:0]        dsr_r;
  logic [32:0]        rem_r;
  logic [NW-1:0]      quo_r;
  logic               neg_r;
  logic [1:0]         dsel_r;
  logic [CW-1:0]      dcnt_r;
  logic               run_r;
  logic signed [31:0] num;
  logic [31:0]        num_mag, det_mag;
  logic [32:0]        rem_sh;
  logic               rem_ge;
  logic signed [31:0] quo_sat;

  logic               out_valid_r;
  logic signed [32:0] uv_sum;
  logic               accept;

  function automatic logic signed [31:0] opnd_val(input opnd_t s);
    case (s)
      OP_ORG0:  return a_r[0];
      OP_ORG1:  return a_r[1];
      OP_ORG2:  return a_r[2];
      OP_DIR0:  return a_r[3];
      OP_DIR1:  return a_r[4];
      OP_DIR2:  return a_r[5];
      OP_NDIR0: return ndir_r[0];
      OP_NDIR1: return ndir_r[1];
      OP_NDIR2: return ndir_r[2];
      OP_E0_0:  return e0_r[0];
      OP_E0_1:  return e0_r[1];
      OP_E0_2:  return e0_r[2];
      OP_E1_0:  return e1_r[0];
      OP_E1_1:  return e1_r[1];
      OP_E1_2:  return e1_r[2];
      OP_SP0:   return sp_r[0];
      OP_SP1:   return sp_r[1];
      OP_SP2:   return sp_r[2];
      OP_C01_0: return c01_r[0];
      OP_C01_1: return c01_r[1];
      OP_C01_2: return c01_r[2];
      OP_CS1_0: return cs1_r[0];
      OP_CS1_1: return cs1_r[1];
      OP_CS1_2: return cs1_r[2];
      OP_C0S_0: return c0s_r[0];
      OP_C0S_1: return c0s_r[1];
      OP_C0S_2: return c0s_r[2];
      OP_T:     return t_r;
      default:  return '0;
    endcase
  endfunction

  always_comb begin
    opa = opnd_val(cmd.mop.sa);
    opb = opnd_val(cmd.mop.sb);
    opc = opnd_val(cmd.mop.sc);
  end

  // Floor shift of the product is an arithmetic shift.
  always_comb begin
    p       = sat32(prod_r >>> FRAC_BITS);
    base    = mop_r.first ? 34'(opc_r) : acc_r;
    acc_new = mop_r.sub ? (base - 34'(p)) : (base + 34'(p));
    acc_sat = sat32(64'(acc_new));
  end

  always_comb begin
    n_eff = (32'(tri_count) > 32'(MAX_TRIANGLES)) ? IW'(MAX_TRIANGLES) : IW'(tri_count);
    case (dsel_r)
      DIV_T:   num = nt_r;
      DIV_U:   num = nu_r;
      default: num = nv_r;
    endcase
    case (cmd.div_sel)
      DIV_T:   num = nt_r;
      DIV_U:   num = nu_r;
      default: num = nv_r;
    endcase
    num_mag = num[31] ? (~num + 32'd1) : num;
    det_mag = det_r[31] ? (~det_r + 32'd1) : det_r;
    rem_sh  = {rem_r[31:0], dvd_r[NW-1]};
    rem_ge  = rem_sh >= {1'b0, dsr_r};
    if (!neg_r) begin
      quo_sat = (quo_r > NW'(32'h7FFF_FFFF)) ? Q_MAX : quo_r[31:0];
    end else begin
      quo_sat = (quo_r > NW'(33'h1_0000_0000 >> 1)) ? Q_MIN : (~quo_r[31:0] + 32'd1);
    end
  end

  always_comb begin
    uv_sum = 33'(u_r) + 33'(v_r);
    accept = (t_r > 0) && !(shadow_r && (t_r < EPS_Q)) && (u_r >= 0) && (v_r >= 0) &&
             (u_r <= ONE_Q) && (v_r <= ONE_Q) && (uv_sum <= 33'(ONE_Q)) &&
             (t_r <= best_r);
  end

  always_comb begin
    sts.n_zero   = (n_eff == '0);
    sts.tri_last = (32'(i_r) + 32'd1 >= 32'(n_eff));
    sts.det_zero = (det_r == '0);
    sts.div_done = run_r && (dcnt_r == '0);
    sts.accept   = accept;
    sts.out_free = !out_valid_r || out_ready;
  end

  // Triangle memory: one write port for loads, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.wr && slot_ok_r) mem[slot_base_r + AW'(cmd.k)] <= a_r[cmd.k];
    if (cmd.rd) rd_data_r <= mem[tri_base_r + AW'(cmd.k)];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r      <= 1'b0;
      mul_v_r     <= 1'b0;
      run_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_v_r  <= cmd.rd;
      mul_v_r <= cmd.mop.valid;
      if (cmd.div_start) run_r <= 1'b1;
      else if (dcnt_r == '0) run_r <= 1'b0;
      if (cmd.finish) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      a_r[0]      <= in_a0;
      a_r[1]      <= in_a1;
      a_r[2]      <= in_a2;
      a_r[3]      <= in_a3;
      a_r[4]      <= in_a4;
      a_r[5]      <= in_a5;
      a_r[6]      <= in_a6;
      a_r[7]      <= in_a7;
      a_r[8]      <= in_a8;
      shadow_r    <= in_shadow_mode;
      slot_base_r <= AW'(32'(in_slot) * WORDS_PER_TRI);
      slot_ok_r   <= 32'(in_slot) < 32'(MAX_TRIANGLES);
    end

    if (cmd.tr_init) begin
      for (int j = 0; j < 3; j++) ndir_r[j] <= sat32(-64'(a_r[3+j]));
      best_r     <= Q_MAX;
      bx_r       <= '0;
      by_r       <= '0;
      bz_r       <= '0;
      idx_r      <= '0;
      found_r    <= 1'b0;
      i_r        <= '0;
      tri_base_r <= '0;
    end

    rd_k_r <= cmd.k;
    // Unpack fetched words into the vertex, edge and offset registers.
    if (rd_v_r) begin
      for (int j = 0; j < 3; j++) begin
        if (rd_k_r == 4'(j)) begin
          v0_r[j] <= rd_data_r;
          sp_r[j] <= sat32(64'(a_r[j]) - 64'(rd_data_r));
        end
        if (rd_k_r == 4'(j + 3)) e0_r[j] <= sat32(64'(rd_data_r) - 64'(v0_r[j]));
        if (rd_k_r == 4'(j + 6)) e1_r[j] <= sat32(64'(rd_data_r) - 64'(v0_r[j]));
      end
    end

    prod_r <= opa * opb;
    opc_r  <= opc;
    mop_r  <= cmd.mop;
    if (mul_v_r) begin
      acc_r <= acc_new;
      if (mop_r.last) begin
        case (mop_r.dst)
          OP_C01_0: c01_r[0] <= acc_sat;
          OP_C01_1: c01_r[1] <= acc_sat;
          OP_C01_2: c01_r[2] <= acc_sat;
          OP_CS1_0: cs1_r[0] <= acc_sat;
          OP_CS1_1: cs1_r[1] <= acc_sat;
          OP_CS1_2: cs1_r[2] <= acc_sat;
          OP_C0S_0: c0s_r[0] <= acc_sat;
          OP_C0S_1: c0s_r[1] <= acc_sat;
          OP_C0S_2: c0s_r[2] <= acc_sat;
          OP_DET:   det_r <= acc_sat;
          OP_NT:    nt_r <= acc_sat;
          OP_NU:    nu_r <= acc_sat;
          OP_NV:    nv_r <= acc_sat;
          OP_BX:    bx_r <= acc_sat;
          OP_BY:    by_r <= acc_sat;
          OP_BZ:    bz_r <= acc_sat;
          default:  ;
        endcase
      end
    end

    // Restoring division of |num| * 2^FRAC_BITS by |det|, one bit a cycle.
    if (cmd.div_start) begin
      dvd_r  <= {num_mag, {FRAC_BITS{1'b0}}};
      dsr_r  <= det_mag;
      rem_r  <= '0;
      quo_r  <= '0;
      neg_r  <= num[31] ^ det_r[31];
      dsel_r <= cmd.div_sel;
      dcnt_r <= CW'(NW);
    end else if (run_r) begin
      if (dcnt_r != '0) begin
        rem_r  <= rem_ge ? (rem_sh - {1'b0, dsr_r}) : rem_sh;
        quo_r  <= {quo_r[NW-2:0], rem_ge};
        dvd_r  <= dvd_r << 1;
        dcnt_r <= dcnt_r - CW'(1);
      end else begin
        case (dsel_r)
          DIV_T:   t_r <= quo_sat;
          DIV_U:   u_r <= quo_sat;
          default: v_r <= quo_sat;
        endcase
      end
    end

    if (cmd.test && accept) begin
      best_r  <= t_r;
      idx_r   <= i_r;
      found_r <= 1'b1;
    end

    if (cmd.next) begin
      i_r        <= i_r + IW'(1);
      tri_base_r <= tri_base_r + AW'(WORDS_PER_TRI);
    end

    if (cmd.finish) begin
      out_hit       <= found_r;
      out_distance  <= best_r;
      out_point_x   <= bx_r;
      out_point_y   <= by_r;
      out_point_z   <= bz_r;
      out_tri_index <= 8'(idx_r);
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

>>> src/ray_triangle_closest_hit.sv
// ---------------------------------------------------------------------------
// ray_triangle_closest_hit: fixed-point ray/triangle closest-hit engine
// Load requests (req_type 0) store one triangle, nine Q16.16 words, in a
// slot and give no result.
// Trace requests (req_type 1) walk the first triangle_count slots and give
// one result: hit flag, closest t, hit point and slot index.
// Both channels use valid/ready; a transfer happens when both are high.
// One request is worked on at a time. A trace takes the triangles in turn;
// for each one whose determinant is not zero, three serial divisions, one
// quotient bit a cycle, make up most of its work, and a triangle that
// becomes the new closest hit also has its hit point worked out.
// A finished result waits in the output register; loads are still accepted,
// but the next trace cannot deliver until the result has been taken.
// triangle_count is written over the APB-style port at address 0.
// Synchronous reset clears the controller, the result valid and the count;
// triangle slots are undefined until loaded.
// ---------------------------------------------------------------------------
`default_nettype none

module ray_triangle_closest_hit import rtch_pkg::*; #(
  parameter int MAX_TRIANGLES = DEF_MAX_TRIANGLES,
  parameter int FRAC_BITS     = DEF_FRAC_BITS
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                psel,
  input  wire                penable,
  input  wire                pwrite,
  input  wire  [2:0]         paddr,
  input  wire  [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  wire                in_valid,
  output logic               in_ready,
  input  wire                in_req_type,
  input  wire  [7:0]         in_slot,
  input  wire  signed [31:0] in_a0,
  input  wire  signed [31:0] in_a1,
  input  wire  signed [31:0] in_a2,
  input  wire  signed [31:0] in_a3,
  input  wire  signed [31:0] in_a4,
  input  wire  signed [31:0] in_a5,
  input  wire  signed [31:0] in_a6,
  input  wire  signed [31:0] in_a7,
  input  wire  signed [31:0] in_a8,
  input  wire                in_shadow_mode,
  output logic               out_valid,
  input  wire                out_ready,
  output logic               out_hit,
  output logic signed [31:0] out_distance,
  output logic signed [31:0] out_point_x,
  output logic signed [31:0] out_point_y,
  output logic signed [31:0] out_point_z,
  output logic [7:0]         out_tri_index
);

  logic [8:0] tri_count_r;
  cmd_t       cmd;
  sts_t       sts;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tri_count_r <= '0;
    end else if (psel && penable && pwrite && (paddr[2] == CFG_TRI_COUNT)) begin
      tri_count_r <= pwdata[8:0];
    end
  end

  always_comb begin
    prdata = (paddr[2] == CFG_TRI_COUNT) ? {23'd0, tri_count_r} : 32'd0;
  end

  rtch_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_req_type(in_req_type),
    .sts        (sts),
    .in_ready   (in_ready),
    .cmd        (cmd)
  );

  rtch_dp #(
    .MAX_TRIANGLES(MAX_TRIANGLES),
    .FRAC_BITS    (FRAC_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .tri_count     (tri_count_r),
    .in_slot       (in_slot),
    .in_a0         (in_a0),
    .in_a1         (in_a1),
    .in_a2         (in_a2),
    .in_a3         (in_a3),
    .in_a4         (in_a4),
    .in_a5         (in_a5),
    .in_a6         (in_a6),
    .in_a7         (in_a7),
    .in_a8         (in_a8),
    .in_shadow_mode(in_shadow_mode),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .out_hit       (out_hit),
    .out_distance  (out_distance),
    .out_point_x   (out_point_x),
    .out_point_y   (out_point_y),
    .out_point_z   (out_point_z),
    .out_tri_index (out_tri_index),
    .sts           (sts)
  );

endmodule

`default_nettype wire
